// ----- hdl/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants and helpers for the line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CMD_DEPTH      = 2;
  localparam int OUT_DEPTH      = 2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Packed width of one front-to-back command for a given coordinate width:
  // load flag, two start coords, three direction/axis flags, decision,
  // hold increment, step increment, pixel count.
  function automatic int cmd_bits(input int cw);
    return 6 * cw + 12;
  endfunction

endpackage

// ----- hdl/bresenham_line_raster.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_raster
// Integer line rasterizer producing one pixel per step item.
// ----------------------------------------------------------------------------
// Input queue: an item transfers on a clock edge with push high and full low.
// mode = load latches two endpoints and sets up the line (no result); mode =
// step asks for the next pixel and yields one result, or none when no line is
// pending. A line yields as many pixels as its major-axis length; the end point
// itself is not drawn, and last marks the final pixel. A load drops any line
// still in progress.
// Result queue: the oldest pixel sits on pixel_x/pixel_y/last while empty is
// low and transfers on an edge with pop high.
// A step item passes through the command queue, then the output queue.
// Throughput: one item per cycle while full is low; load setup is computed
// combinationally, and the unstalled back runs one decision update per cycle.
// Stalls: the back end holds a step while the two-entry output queue is full;
// the two-entry command queue then fills and raises full.
// Reset (rst, synchronous): both queues empty, no line pending.
// ----------------------------------------------------------------------------
module bresenham_line_raster #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last,
  output logic                         empty,
  input  logic                         pop
);

  localparam int CMD_W = brl_pkg::cmd_bits(COORD_BITS);

  logic             cmd_valid;
  logic             cmd_take;
  logic [CMD_W-1:0] cmd_data;

  brl_front #(
    .COORD_BITS (COORD_BITS),
    .DEPTH      (brl_pkg::CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_data  (cmd_data)
  );

  brl_back #(
    .COORD_BITS (COORD_BITS),
    .DEPTH      (brl_pkg::OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_data  (cmd_data),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ----- hdl/brl_fifo.sv -----
// ----------------------------------------------------------------------------
// brl_fifo
// Small flop-based first-in first-out queue with registered count.
// ----------------------------------------------------------------------------
module brl_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = brl_pkg::CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr;
  logic             rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fifo count above depth");

  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |=> !empty)
    else $error("fifo empty after a lone write");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    empty |-> (wr_ptr == rd_ptr))
    else $error("fifo pointers differ while empty");

endmodule

// ----- hdl/brl_front.sv -----
// ----------------------------------------------------------------------------
// brl_front
// Input side: takes items, classifies load/step, works out line setup
// terms for loads, and queues commands for the back end.
// ----------------------------------------------------------------------------
module brl_front #(
  parameter  int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter  int DEPTH      = brl_pkg::CMD_DEPTH,
  localparam int CMD_W      = brl_pkg::cmd_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output logic                         cmd_valid,
  input  logic                         cmd_take,
  output logic [CMD_W-1:0]             cmd_data
);

  localparam int CW = COORD_BITS;

  typedef struct packed {
    logic                 is_load;
    logic signed [CW-1:0] x_start;
    logic signed [CW-1:0] y_start;
    logic                 dir_x_neg;
    logic                 dir_y_neg;
    logic                 x_major;
    logic signed [CW+2:0] decision;
    logic [CW+1:0]        incr_hold;
    logic signed [CW+2:0] incr_step;
    logic [CW-1:0]        remaining;
  } cmd_t;

  logic signed [CW:0] dx_s;
  logic signed [CW:0] dy_s;
  logic signed [CW:0] dx_n;
  logic signed [CW:0] dy_n;
  logic               x_fwd;
  logic               y_fwd;
  logic [CW-1:0]      dx;
  logic [CW-1:0]      dy;
  logic               xmaj;
  logic [CW-1:0]      major;
  logic [CW-1:0]      minor;
  cmd_t               cmd;
  logic               cmd_empty;

  always_comb begin
    dx_s  = {x_end[CW-1], x_end} - {x_start[CW-1], x_start};
    dy_s  = {y_end[CW-1], y_end} - {y_start[CW-1], y_start};
    dx_n  = -dx_s;
    dy_n  = -dy_s;
    x_fwd = !dx_s[CW] && (dx_s != '0);
    y_fwd = !dy_s[CW] && (dy_s != '0);
    // magnitudes fit CW bits unsigned
    dx    = dx_s[CW] ? dx_n[CW-1:0] : dx_s[CW-1:0];
    dy    = dy_s[CW] ? dy_n[CW-1:0] : dy_s[CW-1:0];
    xmaj  = (dy <= dx);
    major = xmaj ? dx : dy;
    minor = xmaj ? dy : dx;

    cmd.is_load   = (mode == brl_pkg::MODE_LOAD);
    cmd.x_start   = x_start;
    cmd.y_start   = y_start;
    cmd.dir_x_neg = !x_fwd;
    cmd.dir_y_neg = !y_fwd;
    cmd.x_major   = xmaj;
    cmd.decision  = {2'b00, minor, 1'b0} - {3'b000, major};
    cmd.incr_hold = {1'b0, minor, 1'b0};
    cmd.incr_step = {2'b00, minor, 1'b0} - {2'b00, major, 1'b0};
    cmd.remaining = major;
  end

  brl_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (CMD_W'(cmd)),
    .full  (full),
    .pop   (cmd_take),
    .dout  (cmd_data),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// ----- hdl/brl_back.sv -----
// ----------------------------------------------------------------------------
// brl_back
// Execution side: holds the line state, applies loads, runs one Bresenham
// step per step command on a pending line, queueing pixels for the receiver.
// ----------------------------------------------------------------------------
module brl_back #(
  parameter  int COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter  int DEPTH      = brl_pkg::OUT_DEPTH,
  localparam int CMD_W      = brl_pkg::cmd_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_take,
  input  logic [CMD_W-1:0]             cmd_data,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last,
  output logic                         empty,
  input  logic                         pop
);

  localparam int CW    = COORD_BITS;
  localparam int OUT_W = 2 * CW + 1;

  typedef struct packed {
    logic                 is_load;
    logic signed [CW-1:0] x_start;
    logic signed [CW-1:0] y_start;
    logic                 dir_x_neg;
    logic                 dir_y_neg;
    logic                 x_major;
    logic signed [CW+2:0] decision;
    logic [CW+1:0]        incr_hold;
    logic signed [CW+2:0] incr_step;
    logic [CW-1:0]        remaining;
  } cmd_t;

  cmd_t                 cmd;
  logic signed [CW-1:0] cur_x;
  logic signed [CW-1:0] cur_y;
  logic signed [CW+2:0] decision;
  logic [CW+1:0]        incr_hold;
  logic signed [CW+2:0] incr_step;
  logic [CW-1:0]        remaining;
  logic                 dir_x_neg;
  logic                 dir_y_neg;
  logic                 x_major;

  logic                 busy;
  logic                 emit;
  logic                 out_full;
  logic                 out_wr;
  logic                 hold;
  logic signed [CW+2:0] decision_next;
  logic signed [CW-1:0] nx;
  logic signed [CW-1:0] ny;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic                 is_last;
  logic [OUT_W-1:0]     out_din;
  logic [OUT_W-1:0]     out_dout;

  assign cmd = cmd_t'(cmd_data);

  assign busy     = (remaining != '0);
  assign emit     = cmd_valid && !cmd.is_load && busy;
  // a load or an idle step never waits on the output queue
  assign cmd_take = cmd_valid && (cmd.is_load || !busy || !out_full);
  assign out_wr   = emit && !out_full;

  always_comb begin
    // x-major holds on d <= 0, y-major on d < 0
    hold = x_major ? (decision[CW+2] || (decision == '0)) : decision[CW+2];
    decision_next = hold ? decision + $signed({1'b0, incr_hold})
                         : decision + incr_step;
    nx      = dir_x_neg ? cur_x - CW'(1) : cur_x + CW'(1);
    ny      = dir_y_neg ? cur_y - CW'(1) : cur_y + CW'(1);
    px      = (x_major || hold) ? cur_x : nx;
    py      = (!x_major || hold) ? cur_y : ny;
    is_last = (remaining == CW'(1));
    out_din = {px, py, is_last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      decision  <= '0;
      incr_hold <= '0;
      incr_step <= '0;
      remaining <= '0;
      dir_x_neg <= 1'b0;
      dir_y_neg <= 1'b0;
      x_major   <= 1'b0;
    end else if (cmd_take) begin
      if (cmd.is_load) begin
        cur_x     <= cmd.x_start;
        cur_y     <= cmd.y_start;
        decision  <= cmd.decision;
        incr_hold <= cmd.incr_hold;
        incr_step <= cmd.incr_step;
        remaining <= cmd.remaining;
        dir_x_neg <= cmd.dir_x_neg;
        dir_y_neg <= cmd.dir_y_neg;
        x_major   <= cmd.x_major;
      end else if (out_wr) begin
        decision  <= decision_next;
        cur_x     <= x_major ? nx : px;
        cur_y     <= x_major ? py : ny;
        remaining <= remaining - 1'b1;
      end
    end
  end

  brl_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_wr),
    .din   (out_din),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty)
  );

  assign pixel_x = out_dout[OUT_W-1:CW+1];
  assign pixel_y = out_dout[CW:1];
  assign last    = out_dout[0];

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    cmd_take && cmd.is_load |=> remaining == $past(cmd.remaining))
    else $error("pixel count not taken from load");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd.is_load && !busy |-> cmd_take && !out_wr)
    else $error("step with no line pending did not drop cleanly");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    out_wr |=> remaining == $past(remaining) - 1'b1)
    else $error("pixel count not decremented on transfer");

  a_step_stall: assert property (@(posedge clk) disable iff (rst)
    emit && out_full |-> !cmd_take)
    else $error("step consumed while output queue full");

endmodule

// ----- dv/bresenham_line_raster_tb.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_raster_tb
// Self-checking testbench for the line rasterizer. A scoreboard class runs
// its own integer line setup and decision update for every accepted item and
// queues the expected pixels. Each popped pixel is compared with the oldest
// one in that queue. Stimulus is a short directed list of corner lines, then
// random load/step sequences. These run under several idle and stall mixes,
// plus one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bresenham_line_raster_tb;

  localparam int CW = brl_pkg::COORD_BITS_DEF;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } pixel_t;

  class pixel_scoreboard;
    int          cur_x, cur_y, decision, hold_inc, step_inc;
    int unsigned remaining;
    bit          dir_x_neg, dir_y_neg, x_major;
    pixel_t      expected_q[$];
    int          errors;

    function new();
      cur_x = 0; cur_y = 0; decision = 0; hold_inc = 0; step_inc = 0;
      remaining = 0; dir_x_neg = 0; dir_y_neg = 0; x_major = 0;
      errors = 0;
    endfunction

    // Track one accepted input transfer; queue the pixel it produces, if any.
    function void note_item(logic m, logic signed [CW-1:0] xs, logic signed [CW-1:0] ys,
                            logic signed [CW-1:0] xe, logic signed [CW-1:0] ye);
      int     ixs, iys, ixe, iye, dx, dy, sx, sy;
      pixel_t px;
      if (m == brl_pkg::MODE_LOAD) begin
        ixs = int'(xs); iys = int'(ys); ixe = int'(xe); iye = int'(ye);
        dx = (ixe > ixs) ? ixe - ixs : ixs - ixe;
        dy = (iye > iys) ? iye - iys : iys - iye;
        dir_x_neg = !(ixe > ixs);
        dir_y_neg = !(iye > iys);
        cur_x = ixs;
        cur_y = iys;
        if (dy <= dx) begin
          x_major = 1;
          decision = 2 * dy - dx;
          hold_inc = 2 * dy;
          step_inc = 2 * (dy - dx);
          remaining = dx;
        end else begin
          x_major = 0;
          decision = 2 * dx - dy;
          hold_inc = 2 * dx;
          step_inc = 2 * (dx - dy);
          remaining = dy;
        end
        return;
      end
      if (remaining == 0) return;
      sx = dir_x_neg ? -1 : 1;
      sy = dir_y_neg ? -1 : 1;
      px.last = (remaining == 1);
      // x-major holds on d <= 0, y-major only on d < 0
      if (x_major) begin
        if (decision <= 0) decision += hold_inc;
        else begin
          decision += step_inc;
          cur_y += sy;
        end
      end else begin
        if (decision < 0) decision += hold_inc;
        else begin
          decision += step_inc;
          cur_x += sx;
        end
      end
      px.x = cur_x[CW-1:0];
      px.y = cur_y[CW-1:0];
      expected_q.push_back(px);
      if (x_major) cur_x += sx;
      else cur_y += sy;
      remaining--;
    endfunction

    function void check_pixel(logic signed [CW-1:0] px, logic signed [CW-1:0] py, logic lst);
      pixel_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected pixel: x %0d y %0d last %0b", px, py, lst);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (px !== want.x) begin
        $error("pixel_x mismatch: expected %0d, actual %0d", want.x, px);
        errors++;
      end
      if (py !== want.y) begin
        $error("pixel_y mismatch: expected %0d, actual %0d", want.y, py);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk, rst;
  logic                 push, full, mode, last, empty, pop;
  logic signed [CW-1:0] x_start, y_start, x_end, y_end, pixel_x, pixel_y;

  pixel_scoreboard sb;
  int send_idle, recv_stall;
  bit hold_req;
  bit hold_armed;
  int hold_left;

  bresenham_line_raster #(.COORD_BITS(CW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .mode    (mode),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .last    (last),
    .empty   (empty),
    .pop     (pop)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // One input transfer; random idle cycles ahead of it.
  task automatic send_item(input logic m, input int xs, input int ys, input int xe,
                           input int ye);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    mode    <= m;
    x_start <= xs[CW-1:0];
    y_start <= ys[CW-1:0];
    x_end   <= xe[CW-1:0];
    y_end   <= ye[CW-1:0];
    do @(posedge clk); while (full);
    sb.note_item(m, xs[CW-1:0], ys[CW-1:0], xe[CW-1:0], ye[CW-1:0]);
  endtask

  task automatic load_line(input int xs, input int ys, input int xe, input int ye);
    send_item(brl_pkg::MODE_LOAD, xs, ys, xe, ye);
  endtask

  // Coordinates are don't-care on a step, so fill them with noise.
  task automatic step_line(input int n);
    repeat (n)
      send_item(brl_pkg::MODE_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic int fit_coord(int base, int delta);
    int v;
    v = base + delta;
    if (v > 2047 || v < -2048) v = base - delta;
    return v;
  endfunction

  // Random line, stepped to its end (plus a few spare steps) or cut short.
  task automatic random_line(output int items);
    int xs, ys, xe, ye, len, n;
    if ($urandom_range(49) == 0) begin
      xs = $signed($urandom_range(4095)) - 2048;
      ys = $signed($urandom_range(4095)) - 2048;
      xe = $signed($urandom_range(4095)) - 2048;
      ye = $signed($urandom_range(4095)) - 2048;
    end else begin
      xs = $signed($urandom_range(4095)) - 2048;
      ys = $signed($urandom_range(4095)) - 2048;
      xe = fit_coord(xs, $urandom_range(8) == 0 ? 0 : $signed($urandom_range(40)) - 20);
      ye = fit_coord(ys, $urandom_range(8) == 0 ? 0 : $signed($urandom_range(40)) - 20);
    end
    len = (xe > xs ? xe - xs : xs - xe);
    if ((ye > ys ? ye - ys : ys - ye) > len) len = (ye > ys ? ye - ys : ys - ye);
    if (len > 64) n = $urandom_range(40, 1);
    else if ($urandom_range(7) == 0) n = $urandom_range(len);
    else n = len + $urandom_range(3);
    load_line(xs, ys, xe, ye);
    step_line(n);
    items = n + 1;
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
    int done, k;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    done = 0;
    while (done < count) begin
      random_line(k);
      done += k;
    end
  endtask

  // Receiver: pops at random, or holds off once for a fixed stretch on request.
  initial begin
    pop = 1'b0;
    hold_left = 0;
    hold_armed = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_armed) begin
        hold_left  = HOLD_CYCLES;
        hold_armed = 1'b1;
      end
      if (rst) pop <= 1'b0;
      else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else pop <= ($urandom_range(99) >= recv_stall);
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_pixel(pixel_x, pixel_y, last);
    end
  end

  initial begin
    #400us;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    mode = brl_pkg::MODE_LOAD;
    x_start = '0;
    y_start = '0;
    x_end = '0;
    y_end = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    step_line(1);                          // nothing pending after reset
    load_line(0, 0, 0, 0);                 // zero length
    step_line(1);
    load_line(-2048, -2048, 2047, 2047);   // full-range diagonal, cut by next load
    step_line(3);
    load_line(2047, 2047, -2048, -2048);
    step_line(2);
    load_line(2047, -2048, -2048, 2047);
    step_line(1);
    load_line(0, 0, 2, 1);                 // x-major tie at d == 0
    step_line(3);
    load_line(0, 0, 1, 2);                 // y-major tie at d == 0
    step_line(2);
    load_line(5, 5, 5, -3);                // vertical, negative direction
    step_line(2);
    load_line(3, 3, 0, 3);                 // horizontal, negative direction
    step_line(3);

    // back-pressure: receiver holds off while a long line streams in
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b1;
    load_line(-100, 0, 50, 30);
    step_line(150);

    random_phase(0, 0, 200);
    random_phase(72, 0, 200);
    random_phase(0, 72, 200);
    random_phase(14, 14, 200);

    @(negedge clk);
    push <= 1'b0;
    recv_stall = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
